// File: sv/mpsm_pkg.sv
// Shared package for the multi-pattern string matcher.
// Holds field widths, request codes, datapath operations and control structs.
// No dependencies.
`default_nettype none

package mpsm_pkg;

	// default sizes of the keyword trie
	localparam int NODE_COUNT_DEF    = 256;
	localparam int ALPHABET_SIZE_DEF = 32;

	// port field widths
	localparam int REQ_W = 3;
	localparam int ID_W  = 8;
	localparam int SYM_W = 5;
	localparam int CNT_W = 9;

	// match counts saturate here
	localparam logic [CNT_W-1:0] COUNT_MAX = 9'd511;

	// request codes
	localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_WRITE   = 3'd1;
	localparam logic [REQ_W-1:0] REQ_BUILD   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_SCAN    = 3'd3;
	localparam logic [REQ_W-1:0] REQ_RESTART = 3'd4;

	// datapath micro-operations, one per controller step
	typedef enum logic [4:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_CLR_STEP,
		OP_REPLY,
		OP_WRITE,
		OP_MISC,
		OP_SC_EVAL,
		OP_SC_FAIL,
		OP_SC_CNT,
		OP_B_SWP,
		OP_B_INIT,
		OP_B_POP,
		OP_B_NODE,
		OP_B_INFO,
		OP_B_FWALK,
		OP_B_FA,
		OP_B_FC,
		OP_B_FSET,
		OP_B_CNT,
		OP_B_CHRD,
		OP_B_CHEV,
		OP_B_CHVS
	} dp_op_t;

	// controller to datapath
	typedef struct packed {
		dp_op_t op;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic sweep_last;
		logic bsweep_last;
		logic sc_edge;
		logic sc_root;
		logic sc_lim;
		logic q_more;
		logic cur_root;
		logic walk_go;
		logic fc_hit;
		logic f_nz;
		logic ch_push;
		logic idx_last;
	} stat_t;

endpackage

`default_nettype wire

// File: sv/mpsm_ctrl.sv
// Controller state machine of the string matcher.
// Sequences clear, write, build and scan steps; depends on mpsm_pkg.
`default_nettype none

module mpsm_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [mpsm_pkg::REQ_W-1:0] req_type,
	input  wire mpsm_pkg::stat_t            stat,
	output mpsm_pkg::cmd_t                  cmd,
	output logic                            busy
);

	typedef enum logic [20:0] {
		S_IDLE  = 21'h000001,
		S_CLR   = 21'h000002,
		S_REPLY = 21'h000004,
		S_WR    = 21'h000008,
		S_MISC  = 21'h000010,
		S_SEV   = 21'h000020,
		S_SFL   = 21'h000040,
		S_SCNT  = 21'h000080,
		S_BSWP  = 21'h000100,
		S_BINIT = 21'h000200,
		S_BPOP  = 21'h000400,
		S_BNODE = 21'h000800,
		S_BINFO = 21'h001000,
		S_BWALK = 21'h002000,
		S_BFA   = 21'h004000,
		S_BFC   = 21'h008000,
		S_BFSET = 21'h010000,
		S_BCNT  = 21'h020000,
		S_BCHRD = 21'h040000,
		S_BCHEV = 21'h080000,
		S_BCHVS = 21'h100000
	} state_t;

	state_t state_q, state_d;
	logic   clr_reply_q, clr_reply_d;

	// next state and operation
	always_comb begin
		state_d     = state_q;
		clr_reply_d = clr_reply_q;
		cmd.op      = mpsm_pkg::OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op      = mpsm_pkg::OP_ACCEPT;
					clr_reply_d = (req_type == mpsm_pkg::REQ_CLEAR);
					unique case (req_type)
						mpsm_pkg::REQ_CLEAR: state_d = S_CLR;
						mpsm_pkg::REQ_WRITE: state_d = S_WR;
						mpsm_pkg::REQ_BUILD: state_d = S_BSWP;
						mpsm_pkg::REQ_SCAN:  state_d = S_SEV;
						default:             state_d = S_MISC;
					endcase
				end
			end
			S_CLR: begin
				cmd.op = mpsm_pkg::OP_CLR_STEP;
				if (stat.sweep_last) state_d = clr_reply_q ? S_REPLY : S_IDLE;
			end
			S_REPLY: begin
				cmd.op  = mpsm_pkg::OP_REPLY;
				state_d = S_IDLE;
			end
			S_WR: begin
				cmd.op  = mpsm_pkg::OP_WRITE;
				state_d = S_IDLE;
			end
			S_MISC: begin
				cmd.op  = mpsm_pkg::OP_MISC;
				state_d = S_IDLE;
			end
			S_SEV: begin
				cmd.op = mpsm_pkg::OP_SC_EVAL;
				priority if (stat.sc_edge) state_d = S_SCNT;
				else if (stat.sc_root)     state_d = S_IDLE;
				else if (stat.sc_lim)      state_d = S_SEV;
				else                       state_d = S_SFL;
			end
			S_SFL: begin
				cmd.op  = mpsm_pkg::OP_SC_FAIL;
				state_d = S_SEV;
			end
			S_SCNT: begin
				cmd.op  = mpsm_pkg::OP_SC_CNT;
				state_d = S_IDLE;
			end
			S_BSWP: begin
				cmd.op = mpsm_pkg::OP_B_SWP;
				if (stat.bsweep_last) state_d = S_BINIT;
			end
			S_BINIT: begin
				cmd.op  = mpsm_pkg::OP_B_INIT;
				state_d = S_BPOP;
			end
			S_BPOP: begin
				cmd.op  = mpsm_pkg::OP_B_POP;
				state_d = stat.q_more ? S_BNODE : S_REPLY;
			end
			S_BNODE: begin
				cmd.op  = mpsm_pkg::OP_B_NODE;
				state_d = S_BINFO;
			end
			S_BINFO: begin
				cmd.op  = mpsm_pkg::OP_B_INFO;
				state_d = stat.cur_root ? S_BFSET : S_BWALK;
			end
			S_BWALK: begin
				cmd.op  = mpsm_pkg::OP_B_FWALK;
				state_d = stat.walk_go ? S_BFA : S_BFSET;
			end
			S_BFA: begin
				cmd.op  = mpsm_pkg::OP_B_FA;
				state_d = S_BFC;
			end
			S_BFC: begin
				cmd.op  = mpsm_pkg::OP_B_FC;
				state_d = stat.fc_hit ? S_BFSET : S_BWALK;
			end
			S_BFSET: begin
				cmd.op  = mpsm_pkg::OP_B_FSET;
				state_d = stat.f_nz ? S_BCNT : S_BCHRD;
			end
			S_BCNT: begin
				cmd.op  = mpsm_pkg::OP_B_CNT;
				state_d = S_BCHRD;
			end
			S_BCHRD: begin
				cmd.op  = mpsm_pkg::OP_B_CHRD;
				state_d = S_BCHEV;
			end
			S_BCHEV: begin
				cmd.op = mpsm_pkg::OP_B_CHEV;
				priority if (stat.ch_push) state_d = S_BCHVS;
				else if (stat.idx_last)    state_d = S_BPOP;
				else                       state_d = S_BCHRD;
			end
			S_BCHVS: begin
				cmd.op  = mpsm_pkg::OP_B_CHVS;
				state_d = stat.idx_last ? S_BPOP : S_BCHRD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register; reset starts the clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_reply_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			clr_reply_q <= clr_reply_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

// File: sv/mpsm_dp.sv
// Datapath of the string matcher: trie, link, count and queue memories.
// Executes one micro-operation per cycle from mpsm_ctrl; depends on mpsm_pkg.
`default_nettype none

module mpsm_dp #(
	parameter int NODE_COUNT    = mpsm_pkg::NODE_COUNT_DEF,
	parameter int ALPHABET_SIZE = mpsm_pkg::ALPHABET_SIZE_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire mpsm_pkg::cmd_t             cmd,
	output mpsm_pkg::stat_t                 stat,
	input  wire logic [mpsm_pkg::REQ_W-1:0] req_type,
	input  wire logic [mpsm_pkg::ID_W-1:0]  node_id,
	input  wire logic [mpsm_pkg::ID_W-1:0]  parent_id,
	input  wire logic [mpsm_pkg::SYM_W-1:0] symbol,
	input  wire logic                       is_end,
	output logic                            status,
	output logic                            matched,
	output logic [mpsm_pkg::ID_W-1:0]       current_node,
	output logic [mpsm_pkg::CNT_W-1:0]      match_count,
	output logic                            done
);

	localparam int NW    = $clog2(NODE_COUNT);
	localparam int CAW   = $clog2(NODE_COUNT * ALPHABET_SIZE);
	localparam int AW    = $clog2(ALPHABET_SIZE);
	localparam int PW    = $clog2(NODE_COUNT + 1);
	localparam int SYW   = mpsm_pkg::SYM_W;
	localparam int CW    = mpsm_pkg::CNT_W;
	localparam int SUM_W = mpsm_pkg::CNT_W + 1;
	localparam int IW    = NW + SYW + 1;
	localparam int CDEP  = NODE_COUNT * ALPHABET_SIZE;

	typedef logic [NW-1:0] node_t;

	// child table address: node * alphabet + symbol
	function automatic logic [CAW-1:0] caddr(input node_t n, input logic [CAW-1:0] s);
		return CAW'(n) * CAW'(ALPHABET_SIZE) + s;
	endfunction

	// memories
	node_t             child_mem [CDEP];
	logic [IW-1:0]     info_mem  [NODE_COUNT];
	node_t             fail_mem  [NODE_COUNT];
	logic [CW-1:0]     cnt_mem   [NODE_COUNT];
	node_t             queue_mem [NODE_COUNT];
	logic              vis_mem   [NODE_COUNT];

	logic              ch_we, in_we, fl_we, ct_we, qu_we, vs_we;
	logic [CAW-1:0]    ch_wa, ch_ra;
	node_t             in_wa, in_ra, fl_wa, fl_ra, ct_wa, ct_ra, qu_wa, qu_ra, vs_wa, vs_ra;
	node_t             ch_wd, fl_wd, qu_wd, ch_rd, fl_rd, qu_rd;
	logic [IW-1:0]     in_wd, in_rd;
	logic [CW-1:0]     ct_wd, ct_rd;
	logic              vs_wd, vs_rd;

	// request fields
	logic [mpsm_pkg::REQ_W-1:0] req_q;
	logic [mpsm_pkg::ID_W-1:0]  nid_q, pid_q;
	logic [SYW-1:0]             sym_q;
	logic                       end_in_q;

	// control registers
	node_t          scan_q;
	logic [CAW-1:0] sw_q;
	logic [PW-1:0]  head_q, tail_q, steps_q;
	logic [AW-1:0]  idx_q;
	logic           done_q;

	// build working registers
	node_t          cur_q, p_q, f_q, c_q;
	logic [SYW-1:0] key_q;
	logic           endm_q;

	// result registers
	logic           status_q, matched_q;
	node_t          node_q;
	logic [CW-1:0]  count_q;

	// derived values
	logic           sym_ok, wr_ok, clr_node, lim;
	node_t          sc_c;
	logic [SUM_W-1:0] csum;
	logic [CW-1:0]  csat;

	logic           emit, e_status, e_matched;
	node_t          e_node;
	logic [CW-1:0]  e_count;

	assign sym_ok   = int'(sym_q) < ALPHABET_SIZE;
	assign sc_c     = sym_ok ? ch_rd : '0;
	assign lim      = steps_q >= PW'(NODE_COUNT);
	assign clr_node = sw_q < CAW'(NODE_COUNT);
	assign wr_ok    = (nid_q != '0) && (int'(nid_q) < NODE_COUNT) &&
	                  (int'(pid_q) < NODE_COUNT) && sym_ok;
	assign csum     = SUM_W'(endm_q) + SUM_W'(ct_rd);
	assign csat     = (csum > SUM_W'(mpsm_pkg::COUNT_MAX)) ? mpsm_pkg::COUNT_MAX
	                                                       : csum[CW-1:0];

	// status to controller
	assign stat.sweep_last  = sw_q == CAW'(CDEP - 1);
	assign stat.bsweep_last = sw_q == CAW'(NODE_COUNT - 1);
	assign stat.sc_edge     = sc_c != '0;
	assign stat.sc_root     = scan_q == '0;
	assign stat.sc_lim      = lim;
	assign stat.q_more      = head_q < tail_q;
	assign stat.cur_root    = cur_q == '0;
	assign stat.walk_go     = (p_q != '0) && !lim;
	assign stat.fc_hit      = ch_rd != '0;
	assign stat.f_nz        = f_q != '0;
	assign stat.ch_push     = (ch_rd != '0) && (tail_q < PW'(NODE_COUNT));
	assign stat.idx_last    = idx_q == AW'(ALPHABET_SIZE - 1);

	// memory ports and result selection
	always_comb begin
		ch_we = 1'b0; ch_wa = sw_q;          ch_wd = '0; ch_ra = caddr(scan_q, CAW'(symbol));
		in_we = 1'b0; in_wa = NW'(sw_q);     in_wd = '0; in_ra = qu_rd;
		fl_we = 1'b0; fl_wa = NW'(sw_q);     fl_wd = '0; fl_ra = scan_q;
		ct_we = 1'b0; ct_wa = NW'(sw_q);     ct_wd = '0; ct_ra = sc_c;
		qu_we = 1'b0; qu_wa = NW'(tail_q);   qu_wd = c_q; qu_ra = NW'(head_q);
		vs_we = 1'b0; vs_wa = c_q;           vs_wd = 1'b1; vs_ra = ch_rd;
		emit = 1'b0; e_status = 1'b0; e_matched = 1'b0; e_node = scan_q; e_count = '0;
		unique case (cmd.op)
			mpsm_pkg::OP_CLR_STEP: begin
				ch_we = 1'b1;
				in_we = clr_node;
				fl_we = clr_node;
				ct_we = clr_node;
			end
			mpsm_pkg::OP_REPLY: begin
				emit = 1'b1;
			end
			mpsm_pkg::OP_WRITE: begin
				ch_we    = wr_ok;
				ch_wa    = caddr(NW'(pid_q), CAW'(sym_q));
				ch_wd    = NW'(nid_q);
				in_we    = wr_ok;
				in_wa    = NW'(nid_q);
				in_wd    = {NW'(pid_q), sym_q, end_in_q};
				emit     = 1'b1;
				e_status = !wr_ok;
			end
			mpsm_pkg::OP_MISC: begin
				emit = 1'b1;
				if (req_q == mpsm_pkg::REQ_RESTART) e_node = '0;
			end
			mpsm_pkg::OP_SC_EVAL: begin
				// limit hit: drop to root and try its edge once more
				ch_ra = caddr('0, CAW'(sym_q));
				if (sc_c == '0 && scan_q == '0) begin
					emit   = 1'b1;
					e_node = '0;
				end
			end
			mpsm_pkg::OP_SC_FAIL: begin
				ch_ra = caddr(fl_rd, CAW'(sym_q));
			end
			mpsm_pkg::OP_SC_CNT: begin
				emit      = 1'b1;
				e_matched = ct_rd != '0;
				e_count   = ct_rd;
			end
			mpsm_pkg::OP_B_SWP: begin
				ct_we = 1'b1;
				vs_we = 1'b1;
				vs_wa = NW'(sw_q);
				vs_wd = 1'b0;
			end
			mpsm_pkg::OP_B_INIT: begin
				qu_we = 1'b1;
				qu_wa = '0;
				qu_wd = '0;
				vs_we = 1'b1;
				vs_wa = '0;
			end
			mpsm_pkg::OP_B_FWALK: begin
				fl_ra = p_q;
			end
			mpsm_pkg::OP_B_FA: begin
				ch_ra = caddr(fl_rd, CAW'(key_q));
			end
			mpsm_pkg::OP_B_FSET: begin
				fl_we = 1'b1;
				fl_wa = cur_q;
				fl_wd = f_q;
				ct_we = f_q == '0;
				ct_wa = cur_q;
				ct_wd = CW'(endm_q);
				ct_ra = f_q;
			end
			mpsm_pkg::OP_B_CNT: begin
				ct_we = 1'b1;
				ct_wa = cur_q;
				ct_wd = csat;
			end
			mpsm_pkg::OP_B_CHRD: begin
				ch_ra = caddr(cur_q, CAW'(idx_q));
			end
			mpsm_pkg::OP_B_CHVS: begin
				vs_we = !vs_rd;
				qu_we = !vs_rd;
			end
			default: begin
			end
		endcase
	end

	// memory arrays, registered reads
	always_ff @(posedge clk) begin
		if (ch_we) child_mem[ch_wa] <= ch_wd;
		ch_rd <= child_mem[ch_ra];
		if (in_we) info_mem[in_wa] <= in_wd;
		in_rd <= info_mem[in_ra];
		if (fl_we) fail_mem[fl_wa] <= fl_wd;
		fl_rd <= fail_mem[fl_ra];
		if (ct_we) cnt_mem[ct_wa] <= ct_wd;
		ct_rd <= cnt_mem[ct_ra];
		if (qu_we) queue_mem[qu_wa] <= qu_wd;
		qu_rd <= queue_mem[qu_ra];
		if (vs_we) vis_mem[vs_wa] <= vs_wd;
		vs_rd <= vis_mem[vs_ra];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= 1'b0;
			scan_q  <= '0;
			sw_q    <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			steps_q <= '0;
			idx_q   <= '0;
		end else begin
			done_q <= emit;
			unique case (cmd.op)
				mpsm_pkg::OP_ACCEPT: begin
					steps_q <= '0;
					sw_q    <= '0;
				end
				mpsm_pkg::OP_CLR_STEP: begin
					sw_q   <= sw_q + 1'b1;
					scan_q <= '0;
				end
				mpsm_pkg::OP_MISC: begin
					if (req_q == mpsm_pkg::REQ_RESTART) scan_q <= '0;
				end
				mpsm_pkg::OP_SC_EVAL: begin
					if (sc_c != '0) scan_q <= sc_c;
					else if (lim)   scan_q <= '0;
				end
				mpsm_pkg::OP_SC_FAIL: begin
					scan_q  <= fl_rd;
					steps_q <= steps_q + 1'b1;
				end
				mpsm_pkg::OP_B_SWP: begin
					sw_q <= sw_q + 1'b1;
				end
				mpsm_pkg::OP_B_INIT: begin
					head_q <= '0;
					tail_q <= PW'(1);
				end
				mpsm_pkg::OP_B_POP: begin
					if (head_q < tail_q) head_q <= head_q + 1'b1;
				end
				mpsm_pkg::OP_B_NODE: begin
					idx_q <= '0;
				end
				mpsm_pkg::OP_B_INFO: begin
					steps_q <= '0;
				end
				mpsm_pkg::OP_B_FC: begin
					if (ch_rd == '0) steps_q <= steps_q + 1'b1;
				end
				mpsm_pkg::OP_B_CHEV: begin
					if (!stat.ch_push) idx_q <= idx_q + 1'b1;
				end
				mpsm_pkg::OP_B_CHVS: begin
					idx_q <= idx_q + 1'b1;
					if (!vs_rd) tail_q <= tail_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// request fields, build working values and results
	always_ff @(posedge clk) begin
		if (cmd.op == mpsm_pkg::OP_ACCEPT) begin
			req_q    <= req_type;
			nid_q    <= node_id;
			pid_q    <= parent_id;
			sym_q    <= symbol;
			end_in_q <= is_end;
		end
		if (cmd.op == mpsm_pkg::OP_B_NODE) cur_q <= qu_rd;
		if (cmd.op == mpsm_pkg::OP_B_INFO) begin
			p_q    <= in_rd[IW-1 -: NW];
			key_q  <= in_rd[SYW:1];
			endm_q <= in_rd[0];
			f_q    <= '0;
		end
		if (cmd.op == mpsm_pkg::OP_B_FA) p_q <= fl_rd;
		if (cmd.op == mpsm_pkg::OP_B_FC && ch_rd != '0) f_q <= ch_rd;
		if (cmd.op == mpsm_pkg::OP_B_CHEV) c_q <= ch_rd;
		if (emit) begin
			status_q  <= e_status;
			matched_q <= e_matched;
			node_q    <= e_node;
			count_q   <= e_count;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign matched      = matched_q;
	assign current_node = mpsm_pkg::ID_W'(node_q);
	assign match_count  = count_q;

	// checks
	a_tail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q <= PW'(NODE_COUNT))
		else $error("queue tail beyond node count");

	a_head_tail: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q)
		else $error("queue head passed tail");

	a_steps: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q <= PW'(NODE_COUNT))
		else $error("failure walk step count overran");

	a_match_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && matched_q) |-> (count_q != '0))
		else $error("match reported with zero count");

endmodule

`default_nettype wire

// File: sv/multi_pattern_string_matcher_unit.sv
// Top level of the multi-pattern string matcher (keyword automaton).
// Instantiates mpsm_ctrl and mpsm_dp; depends on mpsm_pkg.
//
// An item is taken when start is high and busy is low; its single result
// shows for one cycle with done high and cannot be held off. A write, a
// restart or an unknown request goes from its own step straight back to
// idle. A scan reads the edge of the current node and, while none exists,
// follows failure links, each hop being one link-memory read and one
// child-table read. Clear sweeps the child table one entry a cycle; the
// same sweep runs after reset with busy high. Build first clears counts
// over all nodes, then per reached node walks its failure links, sets its
// failure link and count and reads the child of each alphabet symbol.
`default_nettype none

module multi_pattern_string_matcher_unit #(
	parameter int NODE_COUNT    = mpsm_pkg::NODE_COUNT_DEF,
	parameter int ALPHABET_SIZE = mpsm_pkg::ALPHABET_SIZE_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [mpsm_pkg::REQ_W-1:0] req_type,
	input  wire logic [mpsm_pkg::ID_W-1:0]  node_id,
	input  wire logic [mpsm_pkg::ID_W-1:0]  parent_id,
	input  wire logic [mpsm_pkg::SYM_W-1:0] symbol,
	input  wire logic                       is_end,
	output logic                            done,
	output logic                            status,
	output logic                            matched,
	output logic [mpsm_pkg::ID_W-1:0]       current_node,
	output logic [mpsm_pkg::CNT_W-1:0]      match_count
);

	mpsm_pkg::cmd_t  cmd;
	mpsm_pkg::stat_t stat;

	// controller
	mpsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy)
	);

	// datapath
	mpsm_dp #(
		.NODE_COUNT    (NODE_COUNT),
		.ALPHABET_SIZE (ALPHABET_SIZE)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.req_type     (req_type),
		.node_id      (node_id),
		.parent_id    (parent_id),
		.symbol       (symbol),
		.is_end       (is_end),
		.status       (status),
		.matched      (matched),
		.current_node (current_node),
		.match_count  (match_count),
		.done         (done)
	);

endmodule

`default_nettype wire
